[hw/rtl/rss_pkg.sv]
`default_nettype none
package rss_pkg;

	localparam int WINDOW_MAX_DEF       = 1024;
	localparam int SAMPLE_BITS_DEF      = 24;
	localparam int CUMULATIVE_LIMIT_DEF = 65535;
	localparam int WINDOW_BITS          = 11;
	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 11'd10;
	localparam int DEV_BITS             = 24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} rss_state_t;

endpackage
`default_nettype wire

[hw/rtl/rolling_sample_stdev_unit.sv]
`default_nettype none
// A word passes from the edge that accepts it to its result word through these steps in order:
// the sum update (read, then update), the shift-add multiplier (one step per significant bit
// of the count and of the sum magnitude), the restoring divider, the square root and the
// output register.
// One word in flight: the next word is taken only after the result word has left.
// arst_n clears sums, counts, pointer and flags and sets the window to 10; not the store.
module rolling_sample_stdev_unit
	import rss_pkg::*;
#(
	parameter int WINDOW_MAX       = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
	parameter int CUMULATIVE_LIMIT = CUMULATIVE_LIMIT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [WINDOW_BITS-1:0] cfg_wdata,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// tdata: sample [SAMPLE_BITS-1:0], then zero fill to whole bytes.
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// tuser: missing.
	input  wire logic                   s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// tdata: deviation [23:0].
	output logic [DEV_BITS-1:0]         m_tdata,
	// tuser: valid_res [0], cumulative limit reached [1].
	output logic [1:0]                  m_tuser
);

	localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SW    = 2 * SAMPLE_BITS + 16;  // square-sum width
	localparam int SUMW  = SAMPLE_BITS + 17;
	localparam int CW    = 17;
	localparam int PW    = 128;                    // numerator width
	localparam int DW    = 2 * CW;                 // c*(c-1)
	localparam int RW    = 64;                     // quotient kept for the root
	localparam logic [WINDOW_BITS-1:0] WMAX_W = WINDOW_BITS'(WINDOW_MAX);

	rss_state_t state_q, state_d;

	logic [WINDOW_BITS-1:0] window_q;
	logic [SAMPLE_BITS:0]   store [WINDOW_MAX];
	logic [SAMPLE_BITS:0]   rd_q;
	logic signed [SUMW-1:0] sum_q;
	logic [SW-1:0]          sq_q;
	logic [CW-1:0]          cnt_q;
	logic [WINDOW_BITS-1:0] seen_q;
	logic [AW-1:0]          wp_q;
	logic                   lim_q;
	logic signed [SAMPLE_BITS-1:0] samp_q;
	logic                   miss_q;
	logic                   valid_q;

	// Shared datapath registers.
	logic [PW-1:0]  num_q;      // numerator, then quotient
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  den_q;
	logic [7:0]     step_q;
	logic [RW-1:0]  rx_q;
	logic [RW-1:0]  root_q;
	logic [RW-1:0]  bit_q;
	logic [1:0]     mphase_q;
	logic [PW-1:0]  acc_q;
	// Shift-add multiplier operands: the multiplicand moves left, the multiplier right.
	logic [PW-1:0]   mc_q;
	logic [SUMW-1:0] mp_q;

	logic [DEV_BITS-1:0] dev_q;
	logic [1:0]          user_q;
	logic                outv_q;

	assign s_tready = (state_q == ST_IDLE) && !outv_q;
	assign m_tvalid = outv_q;
	assign m_tdata  = dev_q;
	assign m_tuser  = user_q;

	wire accept = s_tvalid && s_tready;

	// Sign-magnitude helpers.
	wire [SAMPLE_BITS-1:0] new_mag = samp_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samp_q)
	                                                      : SAMPLE_BITS'(samp_q);
	wire signed [SAMPLE_BITS-1:0] old_v = $signed(rd_q[SAMPLE_BITS-1:0]);
	wire [SAMPLE_BITS-1:0] old_mag = old_v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-old_v)
	                                                   : SAMPLE_BITS'(old_v);
	wire [SUMW-1:0] sum_mag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

	wire [AW-1:0] wp_mod = (WINDOW_BITS'(wp_q) >= window_q) ? '0 : wp_q;
	wire [AW-1:0] wp_nx  = (WINDOW_BITS'(wp_mod) + 1'b1 >= window_q) ? '0
	                                                               : AW'(wp_mod + 1'b1);

	// Store: written and read in a clocked block.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= store[wp_mod];
		end
		if (state_q == ST_UPDATE && window_q != '0) begin
			store[wp_mod] <= {miss_q, samp_q};
		end
	end

	// Division and root step logic.
	wire [DW:0]   rem_sh  = {rem_q, num_q[PW-1]};
	wire          rem_ge  = rem_sh >= {1'b0, den_q};
	wire [RW-1:0] tri_v   = root_q + bit_q;
	wire          sq_ge   = rx_q >= tri_v;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_READ;
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_MUL;
			ST_MUL:    if (mphase_q == 2'd3) state_d = ST_DIV;
			ST_DIV:    if (step_q == 8'd127) state_d = ST_SQRT;
			ST_SQRT:   if (bit_q == '0) state_d = ST_OUT;
			ST_OUT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			window_q <= WINDOW_RESET;
			sum_q    <= '0;
			sq_q     <= '0;
			cnt_q    <= '0;
			seen_q   <= '0;
			wp_q     <= '0;
			lim_q    <= 1'b0;
			outv_q   <= 1'b0;
			mphase_q <= '0;
			step_q   <= '0;
		end else begin
			state_q <= state_d;
			if (outv_q && m_tready) outv_q <= 1'b0;
			if (state_q == ST_OUT) outv_q <= 1'b1;
			if (cfg_we) begin
				window_q <= (cfg_wdata > WMAX_W) ? WMAX_W : cfg_wdata;
				sum_q    <= '0;
				sq_q     <= '0;
				cnt_q    <= '0;
				seen_q   <= '0;
				wp_q     <= '0;
				lim_q    <= 1'b0;
			end
			case (state_q)
				ST_UPDATE: begin
					mphase_q <= '0;
					if (window_q == '0) begin
						if (!lim_q && !miss_q) begin
							sum_q <= sum_q + SUMW'(samp_q);
							sq_q  <= sq_q + SW'(new_mag * new_mag);
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q + 1'b1 >= CW'(CUMULATIVE_LIMIT)) lim_q <= 1'b1;
						end
					end else begin
						logic signed [SUMW-1:0] s1;
						logic [SW-1:0]          q1;
						logic [CW-1:0]          c1;
						s1 = sum_q;
						q1 = sq_q;
						c1 = cnt_q;
						if (seen_q >= window_q && !rd_q[SAMPLE_BITS] && c1 != '0) begin
							s1 = s1 - SUMW'(old_v);
							q1 = q1 - SW'(old_mag * old_mag);
							c1 = c1 - 1'b1;
						end
						if (!miss_q) begin
							s1 = s1 + SUMW'(samp_q);
							q1 = q1 + SW'(new_mag * new_mag);
							c1 = c1 + 1'b1;
						end
						sum_q <= s1;
						sq_q  <= q1;
						cnt_q <= c1;
						wp_q  <= wp_nx;
						if (seen_q < window_q) seen_q <= seen_q + 1'b1;
					end
				end
				ST_MUL: begin
					// The load and subtract phases advance unconditionally; the two product
					// phases run until their multiplier is used up.
					if (mphase_q == 2'd0 || mphase_q == 2'd3 || mp_q == '0)
						mphase_q <= mphase_q + 1'b1;
					step_q <= '0;
				end
				ST_DIV: step_q <= step_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Payload path: multiply bit by bit, divide, root.
	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= $signed(s_tdata[SAMPLE_BITS-1:0]);
			miss_q <= s_tuser;
		end
		case (state_q)
			ST_MUL: begin
				case (mphase_q)
					2'd0: begin
						mc_q    <= PW'(sq_q);
						mp_q    <= SUMW'(cnt_q);
						acc_q   <= '0;
						den_q   <= DW'(cnt_q) * DW'(cnt_q - 1'b1);
						valid_q <= ((window_q == '0) || (seen_q >= window_q))
						           && (cnt_q >= CW'(2));
					end
					2'd1: begin
						// c * S2 into acc_q, then load S magnitude for its square.
						if (mp_q != '0) begin
							if (mp_q[0]) acc_q <= acc_q + mc_q;
							mc_q <= mc_q << 1;
							mp_q <= mp_q >> 1;
						end else begin
							mc_q  <= PW'(sum_mag);
							mp_q  <= sum_mag;
							num_q <= '0;
						end
					end
					2'd2: begin
						if (mp_q != '0) begin
							if (mp_q[0]) num_q <= num_q + mc_q;
							mc_q <= mc_q << 1;
							mp_q <= mp_q >> 1;
						end
					end
					default: begin
						num_q <= (acc_q < num_q) ? '0 : acc_q - num_q;
						rem_q <= '0;
					end
				endcase
			end
			ST_DIV: begin
				num_q <= {num_q[PW-2:0], rem_ge};
				rem_q <= rem_ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
				if (step_q == 8'd127) begin
					rx_q   <= ({num_q[PW-2:0], rem_ge} >> RW) != '0 ? '1
					          : RW'({num_q[PW-2:0], rem_ge});
					root_q <= '0;
					bit_q  <= {2'b01, {(RW-2){1'b0}}};
				end
			end
			ST_SQRT: begin
				if (bit_q != '0) begin
					if (sq_ge) begin
						rx_q   <= rx_q - tri_v;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			ST_OUT: begin
				if (!valid_q || den_q == '0) dev_q <= '0;
				else if (num_q[PW-1:RW] != '0 || root_q > RW'({DEV_BITS{1'b1}}))
					dev_q <= '1;
				else dev_q <= root_q[DEV_BITS-1:0];
				user_q <= {(window_q == '0) && lim_q, valid_q};
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
